/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL, clocked on clk and
// disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* src/ucb1_pkg.sv */
// ---------------------------------------------------------------------------
// ucb1_pkg
// Types and constants of the UCB1 bandit arm selector.
// ---------------------------------------------------------------------------
package ucb1_pkg;

    localparam int NUM_ARMS   = 16;
    localparam int ARM_BITS   = 4;
    localparam int NARM_BITS  = 5;
    localparam int COUNT_BITS = 32;
    localparam int SUM_BITS   = 48;
    localparam int MEAN_BITS  = 16;
    localparam int LN_BITS    = 21;
    localparam int ROOT_BITS  = 19;
    localparam int EXPL_BITS  = 17;
    localparam int SCORE_BITS = 19;
    localparam int DIVN_BITS  = 49;

    localparam logic [15:0] LN2_Q16        = 16'd45426;
    localparam logic [4:0]  ACTIVE_RESET   = 5'd16;
    localparam logic [15:0] EXPLORE_RESET  = 16'd5793;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_SELECT = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic {
        CFG_ACTIVE_ARMS    = 1'b0,
        CFG_EXPLORE_WEIGHT = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_DIV,
        ST_UPD_WR,
        ST_LOG_NORM,
        ST_LOG_MUL,
        ST_LOG_ADJ,
        ST_LOG_SCALE,
        ST_SCAN_RD,
        ST_SCAN_WAIT,
        ST_SQRT,
        ST_EXPL,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [3:0]        arm;
        logic signed [15:0] reward;
    } in_word_t;

    typedef struct packed {
        logic [3:0]         chosen_arm;
        logic [31:0]        pulls_out;
        logic signed [15:0] mean_out;
        logic               status;
    } out_word_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]       count;
        logic signed [SUM_BITS-1:0]  sum;
        logic signed [MEAN_BITS-1:0] mean;
    } arm_entry_t;

endpackage

/* src/ucb1_bandit_arm_selector.sv */
// ---------------------------------------------------------------------------
// ucb1_bandit_arm_selector
// UCB1 multi-armed bandit: arm table in a synchronous memory, with update,
// select, read and clear operations on a shared sequential datapath.
// ---------------------------------------------------------------------------
// Usage: one input word (operation, arm, reward) is taken on in_valid and
// in_ready; exactly one output word comes back on out_valid and out_ready.
// Words are handled one at a time; in_ready is high only when the sequencer
// is idle. A finished result sits in the output register, so the next input
// word can be taken while the receiver stalls on the previous one.
// An update reads its arm entry, forms the rounded mean in a one-bit-per-cycle
// 49-step divider and writes the entry back. A select first forms the
// logarithm of the total (normalization, repeated squaring, scaling), then
// per scanned arm does a memory read, a 49-step divide, a 19-step square root,
// a multiply and a compare; the divider is shared with update. The scan stops
// at the first unpulled arm.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) that the
// user writes only while the block is idle; the block does not enforce it.
// Reset and clear both clear the valid bits of all table entries (an invalid
// entry reads as zero) and the total pull count; no clearing pass is needed.
// Reset also sets the configuration registers to their defaults.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ucb1_bandit_arm_selector (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ucb1_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ucb1_pkg::out_word_t  out_data,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_data
);

    // Arm table memory and its per-entry valid bits.
    ucb1_pkg::arm_entry_t mem [ucb1_pkg::NUM_ARMS];
    logic [ucb1_pkg::NUM_ARMS-1:0] valid_reg, valid_next;
    ucb1_pkg::arm_entry_t rd_data_reg;
    logic rd_vld_reg;
    logic [ucb1_pkg::ARM_BITS-1:0] rd_addr;
    logic mem_we;
    ucb1_pkg::arm_entry_t wr_data;

    ucb1_pkg::state_t state_reg, state_next;
    ucb1_pkg::op_t op_reg, op_next;
    logic [ucb1_pkg::ARM_BITS-1:0] arm_reg, arm_next;
    logic signed [15:0] reward_reg, reward_next;
    logic [4:0]  active_reg;
    logic [15:0] explore_reg;
    logic [ucb1_pkg::COUNT_BITS-1:0] total_reg, total_next;

    // Divider.
    logic [ucb1_pkg::DIVN_BITS-1:0]  div_num_reg, div_num_next;
    logic [ucb1_pkg::COUNT_BITS-1:0] div_den_reg, div_den_next;
    logic [ucb1_pkg::COUNT_BITS-1:0] div_rem_reg, div_rem_next;
    logic [5:0] div_cnt_reg, div_cnt_next;

    // Update scratch.
    logic [ucb1_pkg::COUNT_BITS-1:0] upd_cnt_reg, upd_cnt_next;
    logic signed [ucb1_pkg::SUM_BITS-1:0] upd_sum_reg, upd_sum_next;
    logic upd_neg_reg, upd_neg_next;

    // Logarithm.
    logic [31:0] mant_reg, mant_next;
    logic [4:0]  k_reg, k_next;
    logic [15:0] frac_reg, frac_next;
    logic [63:0] prod_reg, prod_next;
    logic [3:0]  sq_cnt_reg, sq_cnt_next;
    logic [ucb1_pkg::LN_BITS-1:0] ln_reg, ln_next;

    // Square root.
    logic [37:0] sq_src_reg, sq_src_next;
    logic [23:0] sq_rem_reg, sq_rem_next;
    logic [ucb1_pkg::ROOT_BITS-1:0] root_reg, root_next;
    logic [4:0]  rt_cnt_reg, rt_cnt_next;

    // Scan.
    logic [ucb1_pkg::NARM_BITS-1:0] scan_reg, scan_next;
    logic signed [ucb1_pkg::MEAN_BITS-1:0] cur_mean_reg, cur_mean_next;
    logic [ucb1_pkg::EXPL_BITS-1:0] expl_reg, expl_next;
    logic signed [ucb1_pkg::SCORE_BITS-1:0] best_reg, best_next;
    logic have_reg, have_next;

    ucb1_pkg::out_word_t res_reg, res_next;
    ucb1_pkg::out_word_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    // Combinational temporaries.
    logic [4:0] n_arms;
    ucb1_pkg::arm_entry_t cur;
    logic signed [ucb1_pkg::SUM_BITS:0] sum_wide;
    logic signed [ucb1_pkg::SUM_BITS-1:0] sum_sat;
    logic [ucb1_pkg::SUM_BITS-1:0] sum_mag;
    logic [ucb1_pkg::COUNT_BITS-1:0] cnt_inc;
    logic [ucb1_pkg::COUNT_BITS:0] div_sh;
    logic [32:0] sq_m2;
    logic [36:0] ln_prod;
    logic [23:0] rt_sh;
    logic [23:0] rt_trial;
    logic [34:0] ex_prod;
    logic signed [ucb1_pkg::SCORE_BITS-1:0] score;
    logic [15:0] q16;

    assign n_arms = (active_reg > 5'(ucb1_pkg::NUM_ARMS)) ?
        5'(ucb1_pkg::NUM_ARMS) : active_reg;
    assign in_ready  = (state_reg == ucb1_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        arm_next       = arm_reg;
        reward_next    = reward_reg;
        total_next     = total_reg;
        valid_next     = valid_reg;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;
        div_rem_next   = div_rem_reg;
        div_cnt_next   = div_cnt_reg;
        upd_cnt_next   = upd_cnt_reg;
        upd_sum_next   = upd_sum_reg;
        upd_neg_next   = upd_neg_reg;
        mant_next      = mant_reg;
        k_next         = k_reg;
        frac_next      = frac_reg;
        prod_next      = prod_reg;
        sq_cnt_next    = sq_cnt_reg;
        ln_next        = ln_reg;
        sq_src_next    = sq_src_reg;
        sq_rem_next    = sq_rem_reg;
        root_next      = root_reg;
        rt_cnt_next    = rt_cnt_reg;
        scan_next      = scan_reg;
        cur_mean_next  = cur_mean_reg;
        expl_next      = expl_reg;
        best_next      = best_reg;
        have_next      = have_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mem_we         = 1'b0;
        rd_addr        = arm_reg;

        cur = rd_vld_reg ? rd_data_reg : '0;
        cnt_inc  = cur.count + 1'b1;
        sum_wide = {cur.sum[ucb1_pkg::SUM_BITS-1], cur.sum} + (ucb1_pkg::SUM_BITS+1)'(reward_reg);
        if (sum_wide[ucb1_pkg::SUM_BITS] != sum_wide[ucb1_pkg::SUM_BITS-1])
            sum_sat = sum_wide[ucb1_pkg::SUM_BITS] ?
                {1'b1, {(ucb1_pkg::SUM_BITS-1){1'b0}}} : {1'b0, {(ucb1_pkg::SUM_BITS-1){1'b1}}};
        else
            sum_sat = sum_wide[ucb1_pkg::SUM_BITS-1:0];
        sum_mag = sum_sat[ucb1_pkg::SUM_BITS-1] ? (~sum_sat + 1'b1) : sum_sat;

        div_sh   = {div_rem_reg, div_num_reg[ucb1_pkg::DIVN_BITS-1]};
        sq_m2    = prod_reg[63:31];
        ln_prod  = {k_reg, frac_reg} * ucb1_pkg::LN2_Q16;
        rt_sh    = {sq_rem_reg[21:0], sq_src_reg[37:36]};
        rt_trial = {3'b000, root_reg, 2'b01};
        ex_prod  = explore_reg * root_reg;
        score    = ucb1_pkg::SCORE_BITS'(cur_mean_reg) + $signed({2'b00, expl_reg});
        q16      = div_num_reg[15:0];

        wr_data.count = upd_cnt_reg;
        wr_data.sum   = upd_sum_reg;
        wr_data.mean  = upd_neg_reg ? (~q16 + 1'b1) : q16;

        case (state_reg)
            ucb1_pkg::ST_IDLE:
            begin
                rd_addr = in_data.arm;
                if (in_valid)
                begin
                    op_next     = ucb1_pkg::op_t'(in_data.operation);
                    arm_next    = in_data.arm;
                    reward_next = in_data.reward;
                    res_next    = '0;
                    case (ucb1_pkg::op_t'(in_data.operation))
                        ucb1_pkg::OP_UPDATE, ucb1_pkg::OP_READ:
                        begin
                            if ({1'b0, in_data.arm} >= n_arms)
                            begin
                                res_next.status = 1'b1;
                                state_next = ucb1_pkg::ST_DONE;
                            end
                            else
                                state_next = ucb1_pkg::ST_RD_WAIT;
                        end
                        ucb1_pkg::OP_SELECT:
                        begin
                            scan_next = '0;
                            have_next = 1'b0;
                            if (total_reg == '0)
                            begin
                                ln_next    = '0;
                                state_next = ucb1_pkg::ST_SCAN_RD;
                            end
                            else
                            begin
                                mant_next  = total_reg;
                                k_next     = 5'd31;
                                state_next = ucb1_pkg::ST_LOG_NORM;
                            end
                        end
                        default:
                        begin
                            valid_next = '0;
                            total_next = '0;
                            state_next = ucb1_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            ucb1_pkg::ST_RD_WAIT:
            begin
                if (op_reg == ucb1_pkg::OP_READ)
                begin
                    res_next.pulls_out = cur.count;
                    res_next.mean_out  = cur.mean;
                    state_next = ucb1_pkg::ST_DONE;
                end
                else
                begin
                    if (total_reg != '1)
                        total_next = total_reg + 1'b1;
                    if (cur.count == '1)
                        state_next = ucb1_pkg::ST_DONE;
                    else
                    begin
                        upd_cnt_next = cnt_inc;
                        upd_sum_next = sum_sat;
                        upd_neg_next = sum_sat[ucb1_pkg::SUM_BITS-1];
                        div_num_next = {1'b0, sum_mag} + ucb1_pkg::DIVN_BITS'(cnt_inc >> 1);
                        div_den_next = cnt_inc;
                        div_rem_next = '0;
                        div_cnt_next = '0;
                        state_next   = ucb1_pkg::ST_DIV;
                    end
                end
            end

            ucb1_pkg::ST_DIV:
            begin
                if (div_sh >= {1'b0, div_den_reg})
                begin
                    div_rem_next = ucb1_pkg::COUNT_BITS'(div_sh - {1'b0, div_den_reg});
                    div_num_next = {div_num_reg[ucb1_pkg::DIVN_BITS-2:0], 1'b1};
                end
                else
                begin
                    div_rem_next = div_sh[ucb1_pkg::COUNT_BITS-1:0];
                    div_num_next = {div_num_reg[ucb1_pkg::DIVN_BITS-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == 6'(ucb1_pkg::DIVN_BITS - 1))
                begin
                    if (op_reg == ucb1_pkg::OP_UPDATE)
                        state_next = ucb1_pkg::ST_UPD_WR;
                    else
                    begin
                        sq_src_next = {1'b0, div_num_next[36:0]};
                        sq_rem_next = '0;
                        root_next   = '0;
                        rt_cnt_next = '0;
                        state_next  = ucb1_pkg::ST_SQRT;
                    end
                end
            end

            ucb1_pkg::ST_UPD_WR:
            begin
                mem_we = 1'b1;
                valid_next[arm_reg] = 1'b1;
                state_next = ucb1_pkg::ST_DONE;
            end

            // Shift the total left until its top bit is set; k tracks the
            // position of the leading one.
            ucb1_pkg::ST_LOG_NORM:
            begin
                if (mant_reg[31])
                begin
                    frac_next   = '0;
                    sq_cnt_next = '0;
                    state_next  = ucb1_pkg::ST_LOG_MUL;
                end
                else
                begin
                    mant_next = {mant_reg[30:0], 1'b0};
                    k_next    = k_reg - 1'b1;
                end
            end

            ucb1_pkg::ST_LOG_MUL:
            begin
                prod_next  = mant_reg * mant_reg;
                state_next = ucb1_pkg::ST_LOG_ADJ;
            end

            ucb1_pkg::ST_LOG_ADJ:
            begin
                frac_next   = {frac_reg[14:0], sq_m2[32]};
                mant_next   = sq_m2[32] ? sq_m2[32:1] : sq_m2[31:0];
                sq_cnt_next = sq_cnt_reg + 1'b1;
                state_next  = (sq_cnt_reg == 4'd15) ? ucb1_pkg::ST_LOG_SCALE
                                                    : ucb1_pkg::ST_LOG_MUL;
            end

            ucb1_pkg::ST_LOG_SCALE:
            begin
                ln_next    = ucb1_pkg::LN_BITS'(({1'b0, ln_prod} + 38'd32768) >> 16);
                state_next = ucb1_pkg::ST_SCAN_RD;
            end

            ucb1_pkg::ST_SCAN_RD:
            begin
                rd_addr = scan_reg[ucb1_pkg::ARM_BITS-1:0];
                if (scan_reg >= n_arms)
                    state_next = ucb1_pkg::ST_DONE;
                else
                    state_next = ucb1_pkg::ST_SCAN_WAIT;
            end

            ucb1_pkg::ST_SCAN_WAIT:
            begin
                if (cur.count == '0)
                begin
                    // An unpulled arm wins outright over everything after it.
                    res_next.chosen_arm = scan_reg[ucb1_pkg::ARM_BITS-1:0];
                    state_next = ucb1_pkg::ST_DONE;
                end
                else
                begin
                    cur_mean_next = cur.mean;
                    div_num_next  = ucb1_pkg::DIVN_BITS'({ln_reg, 16'h0000});
                    div_den_next  = cur.count;
                    div_rem_next  = '0;
                    div_cnt_next  = '0;
                    state_next    = ucb1_pkg::ST_DIV;
                end
            end

            // Digit-by-digit integer square root, two radicand bits a step.
            ucb1_pkg::ST_SQRT:
            begin
                sq_src_next = {sq_src_reg[35:0], 2'b00};
                if (rt_sh >= rt_trial)
                begin
                    sq_rem_next = rt_sh - rt_trial;
                    root_next   = {root_reg[ucb1_pkg::ROOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_next = rt_sh;
                    root_next   = {root_reg[ucb1_pkg::ROOT_BITS-2:0], 1'b0};
                end
                rt_cnt_next = rt_cnt_reg + 1'b1;
                if (rt_cnt_reg == 5'(ucb1_pkg::ROOT_BITS - 1))
                    state_next = ucb1_pkg::ST_EXPL;
            end

            ucb1_pkg::ST_EXPL:
            begin
                expl_next  = ucb1_pkg::EXPL_BITS'(({1'b0, ex_prod} + 36'h80000) >> 20);
                state_next = ucb1_pkg::ST_CMP;
            end

            ucb1_pkg::ST_CMP:
            begin
                if (!have_reg || (score > best_reg))
                begin
                    have_next = 1'b1;
                    best_next = score;
                    res_next.chosen_arm = scan_reg[ucb1_pkg::ARM_BITS-1:0];
                end
                scan_next  = scan_reg + 1'b1;
                state_next = ucb1_pkg::ST_SCAN_RD;
            end

            ucb1_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ucb1_pkg::ST_IDLE;
                end
            end

            default:
                state_next = ucb1_pkg::ST_IDLE;
        endcase
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[arm_reg] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ucb1_pkg::ST_IDLE;
            op_reg        <= ucb1_pkg::OP_UPDATE;
            arm_reg       <= '0;
            reward_reg    <= '0;
            total_reg     <= '0;
            valid_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            active_reg    <= ucb1_pkg::ACTIVE_RESET;
            explore_reg   <= ucb1_pkg::EXPLORE_RESET;
            div_num_reg   <= '0;
            div_den_reg   <= '0;
            div_rem_reg   <= '0;
            div_cnt_reg   <= '0;
            upd_cnt_reg   <= '0;
            upd_sum_reg   <= '0;
            upd_neg_reg   <= 1'b0;
            mant_reg      <= '0;
            k_reg         <= '0;
            frac_reg      <= '0;
            prod_reg      <= '0;
            sq_cnt_reg    <= '0;
            ln_reg        <= '0;
            sq_src_reg    <= '0;
            sq_rem_reg    <= '0;
            root_reg      <= '0;
            rt_cnt_reg    <= '0;
            scan_reg      <= '0;
            cur_mean_reg  <= '0;
            expl_reg      <= '0;
            best_reg      <= '0;
            have_reg      <= 1'b0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            arm_reg       <= arm_next;
            reward_reg    <= reward_next;
            total_reg     <= total_next;
            valid_reg     <= valid_next;
            rd_vld_reg    <= valid_reg[rd_addr];
            if (cfg_we)
            begin
                case (ucb1_pkg::cfg_idx_t'(cfg_index))
                    ucb1_pkg::CFG_ACTIVE_ARMS:    active_reg  <= cfg_data[4:0];
                    ucb1_pkg::CFG_EXPLORE_WEIGHT: explore_reg <= cfg_data;
                    default:                      active_reg  <= active_reg;
                endcase
            end
            div_num_reg   <= div_num_next;
            div_den_reg   <= div_den_next;
            div_rem_reg   <= div_rem_next;
            div_cnt_reg   <= div_cnt_next;
            upd_cnt_reg   <= upd_cnt_next;
            upd_sum_reg   <= upd_sum_next;
            upd_neg_reg   <= upd_neg_next;
            mant_reg      <= mant_next;
            k_reg         <= k_next;
            frac_reg      <= frac_next;
            prod_reg      <= prod_next;
            sq_cnt_reg    <= sq_cnt_next;
            ln_reg        <= ln_next;
            sq_src_reg    <= sq_src_next;
            sq_rem_reg    <= sq_rem_next;
            root_reg      <= root_next;
            rt_cnt_reg    <= rt_cnt_next;
            scan_reg      <= scan_next;
            cur_mean_reg  <= cur_mean_next;
            expl_reg      <= expl_next;
            best_reg      <= best_next;
            have_reg      <= have_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A table write always leaves its entry marked valid.
    `ASSERT_NEXT(a_write_sets_valid, mem_we, valid_reg[$past(arm_reg)])
    // Only update writes the table.
    `ASSERT_IMPLY(a_write_only_update, mem_we, op_reg == ucb1_pkg::OP_UPDATE)
    // An out-of-range flag can only come from update or read.
    `ASSERT_IMPLY(a_status_source, (state_reg == ucb1_pkg::ST_DONE) && res_reg.status,
        (op_reg == ucb1_pkg::OP_UPDATE) || (op_reg == ucb1_pkg::OP_READ))
    // A finished clear leaves no valid entry and a zero total behind.
    `ASSERT_IMPLY(a_clear_empties, (state_reg == ucb1_pkg::ST_DONE) &&
        (op_reg == ucb1_pkg::OP_CLEAR), (valid_reg == '0) && (total_reg == '0))

endmodule

/* verif/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UCB1 bandit arm selector. A scoreboard keeps
// its own copy of the arm table and the configuration, works out the one
// result word of every accepted input word, and checks every output word in
// order. Directed words hit the extremes and special cases, then phases of
// random words run under several configurations with random idling on both
// sides, one long receiver stall and one sender pause.
// ---------------------------------------------------------------------------
module tb_top;
    import ucb1_pkg::*;

    // Scoreboard: predicts the arm table and holds the pending result words.
    class bandit_scoreboard;
        longint unsigned pulls[NUM_ARMS];
        longint          sums[NUM_ARMS];
        longint          means[NUM_ARMS];
        longint unsigned total;
        longint unsigned arms_cfg;
        longint unsigned weight_cfg;
        out_word_t       pending[$];

        function new();
            for (int i = 0; i < NUM_ARMS; i++)
            begin
                pulls[i] = 0;
                sums[i]  = 0;
                means[i] = 0;
            end
            total      = 0;
            arms_cfg   = ACTIVE_RESET;
            weight_cfg = EXPLORE_RESET;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [15:0] value);
            if (idx == CFG_ACTIVE_ARMS)
                arms_cfg = value[4:0];
            else
                weight_cfg = value;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        // log2 in Q.16: integer part from the top bit, fraction by squaring.
        function longint unsigned log2_q16(longint unsigned v);
            int unsigned     k;
            longint unsigned t;
            longint unsigned m;
            longint unsigned f;
            k = 0;
            t = v;
            f = 0;
            while (t > 1)
            begin
                t = t >> 1;
                k++;
            end
            m = (k <= 31) ? (v << (31 - k)) : (v >> (k - 31));
            for (int i = 0; i < 16; i++)
            begin
                m = (m * m) >> 31;
                f = f << 1;
                if (m >= (64'd1 << 32))
                begin
                    f = f | 1;
                    m = m >> 1;
                end
            end
            return (longint'(k) << 16) | f;
        endfunction

        // Mean rounded to nearest, ties away from zero.
        function longint round_mean(longint s, longint unsigned c);
            longint unsigned mag;
            longint unsigned q;
            mag = (s < 0) ? longint'(-s) : s;
            q = (mag + c / 2) / c;
            return (s < 0) ? -longint'(q) : longint'(q);
        endfunction

        function out_word_t predict(in_word_t w);
            out_word_t       r;
            int unsigned     n;
            longint          s;
            longint          best;
            longint          score;
            longint unsigned ln;
            longint unsigned expl;
            bit              have;
            bit              got_unpulled;
            longint          sum_max;
            r = '0;
            n = (arms_cfg > NUM_ARMS) ? NUM_ARMS : int'(arms_cfg);
            sum_max = (64'sd1 <<< (SUM_BITS - 1)) - 1;
            case (op_t'(w.operation))
                OP_UPDATE:
                begin
                    if (w.arm >= n)
                        r.status = 1'b1;
                    else
                    begin
                        if (pulls[w.arm] < 64'hFFFF_FFFF)
                        begin
                            s = sums[w.arm] + longint'(w.reward);
                            if (s > sum_max)
                                s = sum_max;
                            if (s < -sum_max - 1)
                                s = -sum_max - 1;
                            pulls[w.arm]++;
                            sums[w.arm]  = s;
                            means[w.arm] = round_mean(s, pulls[w.arm]);
                        end
                        if (total < 64'hFFFF_FFFF)
                            total++;
                    end
                end
                OP_SELECT:
                begin
                    have = 0;
                    got_unpulled = 0;
                    best = 0;
                    ln = 0;
                    if (total > 0)
                        ln = (log2_q16(total) * LN2_Q16 + 32768) >> 16;
                    for (int i = 0; i < n; i++)
                    begin
                        if (pulls[i] == 0)
                        begin
                            if (!got_unpulled)
                            begin
                                got_unpulled = 1;
                                have = 1;
                                r.chosen_arm = 4'(i);
                            end
                        end
                        else if (!got_unpulled)
                        begin
                            expl = (weight_cfg * int_sqrt((ln << 16) / pulls[i])
                                    + (64'd1 << 19)) >> 20;
                            score = means[i] + longint'(expl);
                            if (!have || score > best)
                            begin
                                have = 1;
                                best = score;
                                r.chosen_arm = 4'(i);
                            end
                        end
                    end
                end
                OP_READ:
                begin
                    if (w.arm >= n)
                        r.status = 1'b1;
                    else
                    begin
                        r.pulls_out = pulls[w.arm][31:0];
                        r.mean_out  = means[w.arm][15:0];
                    end
                end
                default:
                begin
                    for (int i = 0; i < NUM_ARMS; i++)
                    begin
                        pulls[i] = 0;
                        sums[i]  = 0;
                        means[i] = 0;
                    end
                    total = 0;
                end
            endcase
            return r;
        endfunction

        function void note_input(in_word_t w);
            pending.push_back(predict(w));
        endfunction

        // Returns an empty string on a match, else a description.
        function string check_result(out_word_t got);
            out_word_t e;
            string     msg;
            if (pending.size() == 0)
                return $sformatf("unexpected output word %h", got);
            e = pending.pop_front();
            msg = "";
            if (got.chosen_arm !== e.chosen_arm)
                msg = {msg, $sformatf(" chosen_arm %0d/%0d", got.chosen_arm, e.chosen_arm)};
            if (got.pulls_out !== e.pulls_out)
                msg = {msg, $sformatf(" pulls_out %0d/%0d", got.pulls_out, e.pulls_out)};
            if (got.mean_out !== e.mean_out)
                msg = {msg, $sformatf(" mean_out %0d/%0d", got.mean_out, e.mean_out)};
            if (got.status !== e.status)
                msg = {msg, $sformatf(" status %0b/%0b", got.status, e.status)};
            if (msg != "")
                msg = {"mismatch (got/expected):", msg};
            return msg;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_word_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_word_t   out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    bandit_scoreboard sb;
    int  error_count;
    int  words_sent;
    int  words_checked;
    int  selects_sent;
    bit  idle_enable;
    bit  long_hold_req;

    ucb1_bandit_arm_selector DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Prints one line per mismatch and keeps the count.
    task automatic report(string msg);
        error_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Output monitor. Values seen right after the edge are the pre-edge ones,
    // so a word counts as taken when valid and ready were both high.
    always @(posedge clk)
    begin
        string msg;
        if (rst_n && out_valid && out_ready)
        begin
            msg = sb.check_result(out_data);
            words_checked++;
            if (msg != "")
                report(msg);
        end
    end

    // Receiver: a random wait before each word while idling is enabled, and one
    // long stall on request so that the block backs up into its input.
    initial
    begin
        int gap;
        out_ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold_req = 0;
            end
            gap = idle_enable ? $urandom_range(0, 7) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Offers one word after a random gap and holds it until it is taken.
    task automatic send_word(in_word_t w);
        int gap;
        gap = idle_enable ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(w);
        words_sent++;
        if (op_t'(w.operation) == OP_SELECT)
            selects_sent++;
    endtask

    task automatic send_op(op_t op, logic [3:0] arm, logic [15:0] reward);
        in_word_t w;
        w.operation = op;
        w.arm       = arm;
        w.reward    = reward;
        send_word(w);
    endtask

    // Drains every pending result, then lets the sequencer settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Registers are only written while the block is idle.
    task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    // Random word: mostly updates and selects on in-range arms, so that
    // every arm gets pulled and the score scan runs to the end.
    task automatic random_word(int n_arms);
        int         pick;
        logic [3:0] arm;
        op_t        op;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            op = OP_UPDATE;
        else if (pick < 75)
            op = OP_SELECT;
        else if (pick < 97)
            op = OP_READ;
        else
            op = OP_CLEAR;
        if (n_arms > 0 && $urandom_range(0, 9) != 0)
            arm = 4'($urandom_range(0, n_arms - 1));
        else
            arm = 4'($urandom);
        send_op(op, arm, 16'($urandom));
    endtask

    initial
    begin
        int arms_list[10];
        int weight_list[10];
        int n;
        arms_list   = '{16, 1, 0, 31, 2, 5, 16, 8, 3, 16};
        weight_list = '{5793, 0, 65535, 5793, 65535, 1000, 0, 20000, 4096, 5793};
        sb = new();
        error_count   = 0;
        words_sent    = 0;
        words_checked = 0;
        selects_sent  = 0;
        idle_enable   = 1;
        long_hold_req = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_ACTIVE_ARMS;
        cfg_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table picks arm 0, reward extremes, ties, clear,
        // shrunk range with out-of-range arms, no active arms.
        send_op(OP_SELECT, 4'd0, 16'h0000);
        send_op(OP_READ, 4'd15, 16'h0000);
        send_op(OP_UPDATE, 4'd0, 16'h7FFF);
        send_op(OP_UPDATE, 4'd15, 16'h8000);
        send_op(OP_UPDATE, 4'd0, 16'h8000);
        send_op(OP_READ, 4'd0, 16'hFFFF);
        send_op(OP_READ, 4'd15, 16'h0000);
        send_op(OP_SELECT, 4'd0, 16'h0000);
        for (int i = 0; i < 16; i++)
            send_op(OP_UPDATE, 4'(i), 16'h0100);
        send_op(OP_SELECT, 4'd0, 16'h0000);
        send_op(OP_CLEAR, 4'd0, 16'h0000);
        send_op(OP_READ, 4'd0, 16'h0000);
        write_reg(CFG_ACTIVE_ARMS, 16'd3);
        send_op(OP_UPDATE, 4'd3, 16'h0200);
        send_op(OP_READ, 4'd3, 16'h0000);
        send_op(OP_UPDATE, 4'd2, 16'h0200);
        write_reg(CFG_ACTIVE_ARMS, 16'd0);
        send_op(OP_UPDATE, 4'd0, 16'h0100);
        send_op(OP_READ, 4'd0, 16'h0000);
        send_op(OP_SELECT, 4'd0, 16'h0000);

        // Random phases, each under its own configuration.
        for (int p = 0; p < 10; p++)
        begin
            write_reg(CFG_ACTIVE_ARMS, 16'(arms_list[p]));
            write_reg(CFG_EXPLORE_WEIGHT,
                      (p == 7) ? 16'($urandom) : 16'(weight_list[p]));
            n = (arms_list[p] > NUM_ARMS) ? NUM_ARMS : arms_list[p];
            idle_enable = (p % 3 != 2);
            if (p == 4)
                long_hold_req = 1;
            for (int k = 0; k < 122; k++)
            begin
                if (p == 6 && k == 60)
                    drain();
                random_word(n);
            end
        end

        drain();
        repeat (100) @(posedge clk);
        $display("Run covered %0d input words (%0d selects), %0d results checked,",
                 words_sent, selects_sent, words_checked);
        $display("under ten configurations with random idling and one long stall.");
        if (error_count == 0 && sb.pending.size() == 0)
            $display("PASS ucb1_bandit_arm_selector");
        else
            $display("FAIL ucb1_bandit_arm_selector");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #20000000;
        $display("Timeout with %0d results outstanding.", sb.pending.size());
        $display("FAIL ucb1_bandit_arm_selector");
        $finish;
    end

endmodule
